// ===== src/vgfc_pkg.sv =====
`default_nettype none

package vgfc_pkg;

    localparam int SIZE_X = 16;
    localparam int SIZE_Y = 16;
    localparam int SIZE_Z = 64;

    localparam int CELLS    = SIZE_X * SIZE_Y * SIZE_Z;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int KIND_W   = 4;
    localparam int ACT_W    = 3;
    localparam int CX_W     = 4;
    localparam int CY_W     = 4;
    localparam int CZ_W     = 6;
    localparam int NOISE_W  = 16;
    localparam int MASK_W   = 6;
    localparam int TOTAL_W  = 3;
    localparam int COUNT_W  = 20;
    localparam int K_W      = $clog2(SIZE_Z);
    localparam int HEIGHT_W = $clog2(SIZE_Z + 1);
    localparam int PROD_W   = NOISE_W + HEIGHT_W + 1;

    localparam logic [ACT_W-1:0] ACT_WRITE   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_COLUMN  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_NOISE3D = 3'd2;
    localparam logic [ACT_W-1:0] ACT_QUERY   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd4;

    localparam logic [KIND_W-1:0] KIND_AIR   = 4'd0;
    localparam logic [KIND_W-1:0] KIND_STONE = 4'd1;

    typedef logic [ADDR_W-1:0] t_addr;

    function automatic logic [TOTAL_W-1:0] face_count(input logic [MASK_W-1:0] mask);
        logic [TOTAL_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < MASK_W; i++) begin
            sum = sum + TOTAL_W'(mask[i]);
        end
        return sum;
    endfunction

endpackage

`default_nettype wire

// ===== src/vgfc_ram.sv =====
`default_nettype none

module vgfc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== src/voxel_grid_face_culler.sv =====
// channel | direction | handshake                  | payload
// input   | in        | i_in_valid / o_in_ready    | i_action i_coord_x/y/z i_block_kind
//         |           |                            | i_noise_sample
// output  | out       | o_out_valid / i_out_ready  | o_face_mask o_vertex_base
//         |           |                            | o_face_total o_solid
//
// one item at a time: write and 3d fill pass through a write state, clear and unused codes go
// straight to done, face query makes seven reads through the single read port of the voxel ram,
// column fill computes a height, then makes one ram write per z entry through the write port.
// synchronous active-low reset clears the sequencer, output valid and vertex count;
// the voxel ram is not cleared and holds garbage until written.
// the result sits in an output register; a stalled output only holds the item
// that would load a second result.
`default_nettype none

module voxel_grid_face_culler
    import vgfc_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [ACT_W-1:0]          i_action,
    input  wire logic [CX_W-1:0]           i_coord_x,
    input  wire logic [CY_W-1:0]           i_coord_y,
    input  wire logic [CZ_W-1:0]           i_coord_z,
    input  wire logic [KIND_W-1:0]         i_block_kind,
    input  wire logic signed [NOISE_W-1:0] i_noise_sample,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [MASK_W-1:0]              o_face_mask,
    output logic [COUNT_W-1:0]             o_vertex_base,
    output logic [TOTAL_W-1:0]             o_face_total,
    output logic                           o_solid
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WRITE  = 3'd1;
    localparam logic [2:0] S_HEIGHT = 3'd2;
    localparam logic [2:0] S_FILL   = 3'd3;
    localparam logic [2:0] S_QUERY  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    localparam logic [2:0] STEP_SELF = 3'd0;
    localparam logic [2:0] STEP_PX   = 3'd1;
    localparam logic [2:0] STEP_PY   = 3'd2;
    localparam logic [2:0] STEP_MX   = 3'd3;
    localparam logic [2:0] STEP_MY   = 3'd4;
    localparam logic [2:0] STEP_PZ   = 3'd5;
    localparam logic [2:0] STEP_MZ   = 3'd6;
    localparam logic [2:0] STEP_LAST = 3'd7;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [CX_W-1:0]       r_x;
    logic [CY_W-1:0]       r_y;
    logic [CZ_W-1:0]       r_z;
    logic [KIND_W-1:0]     r_wdata;
    logic [NOISE_W-1:0]    r_noise;
    logic [ACT_W-1:0]      r_action;
    logic                  r_query_ok;
    logic [HEIGHT_W-1:0]   r_height;
    logic [K_W-1:0]        r_k;
    logic [2:0]            r_step;
    logic                  r_rd_pend;
    logic [2:0]            r_rd_idx;
    logic                  r_rd_oob;
    logic                  r_solid;
    logic [MASK_W-1:0]     r_mask;
    logic [COUNT_W-1:0]    r_count;
    logic                  r_out_valid;
    logic [MASK_W-1:0]     r_out_mask;
    logic [COUNT_W-1:0]    r_out_base;
    logic [TOTAL_W-1:0]    r_out_total;
    logic                  r_out_solid;

    logic                  in_fire;
    logic                  in_xy;
    logic                  in_xyz;
    logic                  done_load;
    t_addr                 ax;
    t_addr                 ay;
    t_addr                 az;
    t_addr                 mem_addr;
    logic                  nb_oob;
    logic                  wr_en;
    logic [KIND_W-1:0]     wr_data;
    logic [KIND_W-1:0]     rd_data;
    logic [PROD_W-1:0]     prod;
    logic [PROD_W-17:0]    h_raw;
    logic [MASK_W-1:0]     fin_mask;
    logic [TOTAL_W-1:0]    fin_total;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign in_xy      = (32'(i_coord_x) < SIZE_X) && (32'(i_coord_y) < SIZE_Y);
    assign in_xyz     = in_xy && (32'(i_coord_z) < SIZE_Z);
    assign done_load  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // shared address unit: item voxel, column entry or query neighbour
    always_comb begin
        ax     = t_addr'(r_x);
        ay     = t_addr'(r_y);
        az     = t_addr'(r_z);
        nb_oob = 1'b0;
        if (r_state == S_FILL) begin
            az = t_addr'(r_k);
        end else if (r_state == S_QUERY) begin
            case (r_step)
                STEP_PX: begin
                    nb_oob = (32'(r_x) + 32'd1) >= SIZE_X;
                    ax     = t_addr'(r_x) + t_addr'(1);
                end
                STEP_PY: begin
                    nb_oob = (32'(r_y) + 32'd1) >= SIZE_Y;
                    ay     = t_addr'(r_y) + t_addr'(1);
                end
                STEP_MX: begin
                    nb_oob = (r_x == '0);
                    ax     = t_addr'(r_x) - t_addr'(1);
                end
                STEP_MY: begin
                    nb_oob = (r_y == '0);
                    ay     = t_addr'(r_y) - t_addr'(1);
                end
                STEP_PZ: begin
                    nb_oob = (32'(r_z) + 32'd1) >= SIZE_Z;
                    az     = t_addr'(r_z) + t_addr'(1);
                end
                STEP_MZ: begin
                    nb_oob = (r_z == '0);
                    az     = t_addr'(r_z) - t_addr'(1);
                end
                default: ;
            endcase
        end
        mem_addr = az * t_addr'(SIZE_X * SIZE_Y) + ay * t_addr'(SIZE_X) + ax;
    end

    assign wr_en   = (r_state == S_WRITE) || (r_state == S_FILL);
    assign wr_data = (r_state == S_FILL)
                   ? ((HEIGHT_W'(r_k) < r_height) ? KIND_STONE : KIND_AIR)
                   : r_wdata;

    // height = ((n + 32768) * Z + 32768) >> 16, sign flip gives n + 32768
    assign prod  = PROD_W'({~r_noise[NOISE_W-1], r_noise[NOISE_W-2:0]}) * PROD_W'(SIZE_Z)
                 + PROD_W'(32768);
    assign h_raw = prod[PROD_W-1:16];

    vgfc_ram #(
        .WIDTH(KIND_W),
        .DEPTH(CELLS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (mem_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (mem_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    unique case (i_action)
                        ACT_WRITE, ACT_NOISE3D: n_state = in_xyz ? S_WRITE : S_DONE;
                        ACT_COLUMN:             n_state = in_xy ? S_HEIGHT : S_DONE;
                        ACT_QUERY:              n_state = in_xyz ? S_QUERY : S_DONE;
                        default:                n_state = S_DONE;
                    endcase
                end
            end
            S_WRITE:  n_state = S_DONE;
            S_HEIGHT: n_state = S_FILL;
            S_FILL:   n_state = (r_k == K_W'(SIZE_Z - 1)) ? S_DONE : S_FILL;
            S_QUERY:  n_state = (r_step == STEP_LAST) ? S_DONE : S_QUERY;
            S_DONE:   n_state = done_load ? S_IDLE : S_DONE;
            default:  n_state = S_IDLE;
        endcase
    end

    assign fin_mask  = (r_query_ok && r_solid) ? r_mask : '0;
    assign fin_total = face_count(fin_mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_rd_pend   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (done_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (done_load) begin
                if (r_query_ok) begin
                    r_count <= r_count + COUNT_W'({fin_total, 2'b00});
                end else if (r_action == ACT_CLEAR) begin
                    r_count <= '0;
                end
            end
            r_rd_pend <= (r_state == S_QUERY) && (r_step != STEP_LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_x        <= i_coord_x;
            r_y        <= i_coord_y;
            r_z        <= i_coord_z;
            r_noise    <= i_noise_sample;
            r_action   <= i_action;
            r_query_ok <= (i_action == ACT_QUERY) && in_xyz;
            r_wdata    <= (i_action == ACT_WRITE) ? i_block_kind
                        : (i_noise_sample[NOISE_W-1] ? KIND_STONE : KIND_AIR);
            r_k        <= '0;
            r_step     <= STEP_SELF;
            r_solid    <= 1'b0;
            r_mask     <= '0;
        end
        if (r_state == S_HEIGHT) begin
            r_height <= (h_raw > (PROD_W - 16)'(SIZE_Z)) ? HEIGHT_W'(SIZE_Z) : HEIGHT_W'(h_raw);
        end
        if (r_state == S_FILL) begin
            r_k <= r_k + K_W'(1);
        end
        if (r_state == S_QUERY) begin
            r_step   <= r_step + 3'd1;
            r_rd_idx <= r_step;
            r_rd_oob <= nb_oob;
        end
        // read data lands in the cycle after its address
        if (r_rd_pend) begin
            if (r_rd_idx == STEP_SELF) begin
                r_solid <= (rd_data != KIND_AIR);
            end else begin
                r_mask[r_rd_idx - 3'd1] <= r_rd_oob || (rd_data == KIND_AIR);
            end
        end
        if (done_load) begin
            r_out_mask  <= fin_mask;
            r_out_total <= fin_total;
            r_out_base  <= r_query_ok ? r_count : '0;
            r_out_solid <= r_query_ok && r_solid;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_face_mask   = r_out_mask;
    assign o_vertex_base = r_out_base;
    assign o_face_total  = r_out_total;
    assign o_solid       = r_out_solid;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("block ready right after taking an item");

    a_faces_need_solid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_face_mask != '0)) |-> o_solid)
        else $error("faces reported for an air voxel");

    a_total_matches_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_face_total) == $countones(o_face_mask)))
        else $error("face total disagrees with mask");

    a_query_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QUERY && r_step == STEP_LAST) |=> (r_state == S_DONE))
        else $error("query sequence did not finish");

    a_count_held_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> $stable(r_count))
        else $error("vertex count moved while idle");

endmodule

`default_nettype wire
